@@ sv/ats_pkg.sv @@
// shared constants, register map and arctangent table for the aim tracking step
// no dependencies; imported by ats_sqrt, ats_cordic and aim_track_step_top
`timescale 1ns / 1ps

package ats_pkg;

  localparam int DEF_ANGLE_BITS = 16;
  localparam int DEF_COORD_BITS = 24;

  // fraction bits added below the coordinate scale
  localparam int GUARD = 14;
  // cordic rotation iterations
  localparam int ITERS = 20;
  // quotient bits of the sine divider
  localparam int QBITS = 16;

  // cordic gain in q16, applied to the divisor
  localparam logic [16:0] GAIN_Q16 = 17'd107922;

  localparam logic [14:0] DEAD_ZONE_RESET = 15'd328;
  localparam logic [16:0] SINE_POS_MAX    = 17'd32767;
  localparam logic [16:0] SINE_NEG_MAX    = 17'd32768;

  // register index, decoded from paddr[2]
  localparam logic REG_DEAD_ZONE = 1'b0;

  // atan(2^-i), 2^32 per turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2F9;
      15:      v = 32'h0000517C;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A2F;
      19:      v = 32'h00000517;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ sv/aim_track_step_top.sv @@
// aim tracking step: square roots, cordic rotation, sine divider and angle step
// depends on ats_pkg, ats_sqrt and ats_cordic
`timescale 1ns / 1ps

// Takes one request per clock while the result output is not held, and returns
// one result per request, in order. A request passes through the input,
// squaring and summing registers, the two square root pipelines, the quadrant
// folding register, 20 cordic iterations, the gain correction and range check
// registers, 16 quotient bits of the divider and one output register.
// When the result at the output is not taken the whole pipeline holds and
// req_ready drops; nothing is lost or repeated. dead_zone is written through
// the apb port at address 0 and should only change while no request is in
// flight.

module aim_track_step_top import ats_pkg::*; #(
  parameter int ANGLE_BITS = DEF_ANGLE_BITS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  // apb configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // request channel
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic                         mode,
  input  logic signed [COORD_BITS-1:0] target_x,
  input  logic signed [COORD_BITS-1:0] target_y,
  input  logic signed [COORD_BITS-1:0] target_z,
  input  logic [ANGLE_BITS-1:0]        current_angle,
  input  logic [13:0]                  step_size,
  // result channel
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [ANGLE_BITS-1:0]        new_angle,
  output logic signed [15:0]           sine,
  output logic                         degenerate
);

  localparam int AB     = ANGLE_BITS;
  localparam int C      = COORD_BITS;
  localparam int RW     = C + GUARD;
  localparam int SW     = 2 * C;
  localparam int CW     = C + 17;
  localparam int PW     = RW + 17;
  localparam int DKW    = RW + 2;
  localparam int DW     = CW + 18;
  localparam int SAW    = 1 + AB + 14 + 3 * C;
  localparam int SA_LEN = RW + 3;
  localparam int SBW    = 1 + AB + 14 + RW;
  localparam int TW     = 2 + AB + 14;
  localparam int NSTG   = RW + 45;

  // ---------------------------------------------------------------- config
  logic [14:0] dead_zone;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DEAD_ZONE) ? {17'd0, dead_zone} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone <= DEAD_ZONE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DEAD_ZONE) begin
      dead_zone <= pwdata[14:0];
    end
  end

  // ---------------------------------------------------------------- control
  logic            en;
  logic [NSTG-1:0] vld;

  assign en        = ~vld[NSTG-1] | res_ready;
  assign req_ready = en;
  assign res_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], req_valid};
    end
  end

  // ---------------------------------------------------------------- input side band
  // {mode, angle, step, x, y, z} follows the square roots
  logic [SAW-1:0] sa [SA_LEN];

  always_ff @(posedge clk) begin
    if (en) begin
      sa[0] <= {mode, current_angle, step_size, target_x, target_y, target_z};
    end
  end

  for (genvar k = 1; k < SA_LEN; k++) begin : g_sa
    always_ff @(posedge clk) begin
      if (en) begin
        sa[k] <= sa[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- squares
  logic signed [C-1:0]  x0, y0, z0;
  logic signed [SW-1:0] xsq, ysq, zsq;
  logic [SW-1:0]        xx_q, yy_q, zz_q;
  logic [SW-1:0]        sxz_q, srad_q;
  logic                 mode1;

  assign x0 = sa[0][3*C-1 -: C];
  assign y0 = sa[0][2*C-1 -: C];
  assign z0 = sa[0][C-1:0];

  assign xsq = x0 * x0;
  assign ysq = y0 * y0;
  assign zsq = z0 * z0;

  assign mode1 = sa[1][SAW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      xx_q   <= $unsigned(xsq);
      yy_q   <= $unsigned(ysq);
      zz_q   <= $unsigned(zsq);
      sxz_q  <= xx_q + zz_q;
      srad_q <= mode1 ? (xx_q + yy_q + zz_q) : (xx_q + zz_q);
    end
  end

  // ---------------------------------------------------------------- square roots
  logic [RW-1:0] h_r, den_r;

  ats_sqrt #(.RW(RW)) u_sqrt_h (
    .clk  (clk),
    .en   (en),
    .rad  ({sxz_q, {(2*GUARD){1'b0}}}),
    .root (h_r)
  );

  ats_sqrt #(.RW(RW)) u_sqrt_den (
    .clk  (clk),
    .en   (en),
    .rad  ({srad_q, {(2*GUARD){1'b0}}}),
    .root (den_r)
  );

  // ---------------------------------------------------------------- quadrant fold
  logic                 mode_s;
  logic [AB-1:0]        angle_s;
  logic [13:0]          step_s;
  logic [C-1:0]         xr, yr, zr;
  logic signed [CW-1:0] xe, ye, ze, he;
  logic signed [CW-1:0] p0, q0, pf, qf;
  logic [31:0]          theta;
  logic signed [CW-1:0] pq_p, pq_q;
  logic signed [31:0]   pq_w;
  logic [SBW-1:0]       sb [ITERS+1];

  assign {mode_s, angle_s, step_s, xr, yr, zr} = sa[SA_LEN-1];

  assign xe = {{(CW-C-GUARD){xr[C-1]}}, xr, {GUARD{1'b0}}};
  assign ye = {{(CW-C-GUARD){yr[C-1]}}, yr, {GUARD{1'b0}}};
  assign ze = {{(CW-C-GUARD){zr[C-1]}}, zr, {GUARD{1'b0}}};
  assign he = {{(CW-RW){1'b0}}, h_r};

  // yaw rotates (z, x), pitch rotates (h, y)
  assign p0 = mode_s ? he : ze;
  assign q0 = mode_s ? ye : xe;

  assign theta = 32'd0 - {angle_s, {(32-AB){1'b0}}};

  always_comb begin
    case (theta[31:30])
      2'd0: begin
        pf = p0;
        qf = q0;
      end
      2'd1: begin
        pf = -q0;
        qf = p0;
      end
      2'd2: begin
        pf = -p0;
        qf = -q0;
      end
      2'd3: begin
        pf = q0;
        qf = -p0;
      end
      default: begin
        pf = p0;
        qf = q0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pq_p  <= pf;
      pq_q  <= qf;
      pq_w  <= {2'b00, theta[29:0]};
      sb[0] <= {mode_s, angle_s, step_s, den_r};
    end
  end

  for (genvar k = 1; k <= ITERS; k++) begin : g_sb
    always_ff @(posedge clk) begin
      if (en) begin
        sb[k] <= sb[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- cordic
  logic signed [CW-1:0] ra, rb;

  ats_cordic #(.CW(CW)) u_cordic (
    .clk   (clk),
    .en    (en),
    .p_in  (pq_p),
    .q_in  (pq_q),
    .w_in  (pq_w),
    .p_out (ra),
    .q_out (rb)
  );

  // ---------------------------------------------------------------- gain correction
  logic                 mode_c;
  logic [AB-1:0]        angle_c;
  logic [13:0]          step_c;
  logic [RW-1:0]        den_c;
  logic signed [CW-1:0] val;
  logic                 neg_c;
  logic [CW-1:0]        mag_c;

  assign {mode_c, angle_c, step_c, den_c} = sb[ITERS];

  // yaw takes the first component negated, pitch the second
  assign val   = mode_c ? rb : ra;
  assign neg_c = mode_c ? rb[CW-1] : (!ra[CW-1] && ra != '0);
  assign mag_c = val[CW-1] ? $unsigned(-val) : $unsigned(val);

  logic [CW-1:0]  mag1, mag2;
  logic [PW-1:0]  prod1;
  logic [TW-1:0]  t1, t2, t3;
  logic [PW:0]    prod_rnd;
  logic [DKW-1:0] dk_raw, dk2, dk3;
  logic [DW-1:0]  n3;

  assign prod_rnd = {1'b0, prod1} + (PW+1)'(32768);
  assign dk_raw   = prod_rnd[PW:16];

  always_ff @(posedge clk) begin
    if (en) begin
      mag1  <= mag_c;
      prod1 <= PW'(den_c * GAIN_Q16);
      t1    <= {neg_c, den_c == '0, angle_c, step_c};
      mag2  <= mag1;
      dk2   <= (dk_raw == '0) ? DKW'(1) : dk_raw;
      t2    <= t1;
      n3    <= DW'({mag2, 15'd0}) + DW'(dk2 >> 1);
      dk3   <= dk2;
      t3    <= t2;
    end
  end

  // ---------------------------------------------------------------- divider
  logic [DW-1:0]    rr   [QBITS+1];
  logic [QBITS-1:0] qq   [QBITS+1];
  logic [DKW-1:0]   dkv  [QBITS+1];
  logic [TW-1:0]    tv   [QBITS+1];
  logic             ovfv [QBITS+1];

  // quotient at or above 2^16 saturates anyway
  always_ff @(posedge clk) begin
    if (en) begin
      rr[0]   <= n3;
      qq[0]   <= '0;
      dkv[0]  <= dk3;
      tv[0]   <= t3;
      ovfv[0] <= n3 >= DW'({dk3, 16'd0});
    end
  end

  for (genvar j = 1; j <= QBITS; j++) begin : g_div
    logic [DW-1:0] dsh;

    assign dsh = DW'(dkv[j-1]) << (QBITS - j);

    always_ff @(posedge clk) begin
      if (en) begin
        dkv[j]  <= dkv[j-1];
        tv[j]   <= tv[j-1];
        ovfv[j] <= ovfv[j-1];
        if (rr[j-1] >= dsh) begin
          rr[j] <= rr[j-1] - dsh;
          qq[j] <= {qq[j-1][QBITS-2:0], 1'b1};
        end else begin
          rr[j] <= rr[j-1];
          qq[j] <= {qq[j-1][QBITS-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------------------------------------------------------- clip, dead zone, step
  logic          neg_f, degen_f, ovf_f;
  logic [AB-1:0] angle_f;
  logic [13:0]   step_f;
  logic [16:0]   qf17, smag;
  logic [15:0]   sine_v;
  logic [AB+13:0] ang_add, ang_sub;
  logic [AB-1:0] angle_v;

  assign {neg_f, degen_f, angle_f, step_f} = tv[QBITS];
  assign ovf_f = ovfv[QBITS];
  assign qf17  = {1'b0, qq[QBITS]};

  assign ang_add = (AB+14)'(angle_f) + (AB+14)'(step_f);
  assign ang_sub = (AB+14)'(angle_f) - (AB+14)'(step_f);

  always_comb begin
    if (neg_f) begin
      smag   = (ovf_f || qf17 > SINE_NEG_MAX) ? SINE_NEG_MAX : qf17;
      sine_v = 16'(17'd0 - smag);
    end else begin
      smag   = (ovf_f || qf17 > SINE_POS_MAX) ? SINE_POS_MAX : qf17;
      sine_v = smag[15:0];
    end
    angle_v = angle_f;
    if (degen_f) begin
      sine_v = '0;
    end else if (smag > {2'b00, dead_zone}) begin
      angle_v = neg_f ? ang_sub[AB-1:0] : ang_add[AB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      new_angle  <= angle_v;
      sine       <= sine_v;
      degenerate <= degen_f;
    end
  end

endmodule

@@ sv/ats_sqrt.sv @@
// pipelined integer square root, one root bit per register stage
// depends on ats_pkg
`timescale 1ns / 1ps

module ats_sqrt import ats_pkg::*; #(
  parameter int RW = DEF_COORD_BITS + GUARD
) (
  input  logic              clk,
  input  logic              en,
  input  logic [2*RW-1:0]   rad,
  output logic [RW-1:0]     root
);

  localparam int RMW = RW + 3;

  logic [2*RW-1:0] rad_q  [RW];
  logic [RMW-1:0]  rem_q  [RW];
  logic [RW-1:0]   root_q [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [2*RW-1:0] rad_in;
    logic [RMW-1:0]  rem_in;
    logic [RW-1:0]   root_in;
    logic [RMW-1:0]  rem_sh;
    logic [RMW-1:0]  trial;

    if (i == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    // bring down the next two radicand bits, try 4*root+1
    assign rem_sh = {rem_in[RMW-3:0], rad_in[2*RW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[i] <= rad_in << 2;
        if (rem_sh >= trial) begin
          rem_q[i]  <= rem_sh - trial;
          root_q[i] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_q[i]  <= rem_sh;
          root_q[i] <= {root_in[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

@@ sv/ats_cordic.sv @@
// pipelined cordic rotator, one micro-rotation per register stage
// depends on ats_pkg (arctangent table)
`timescale 1ns / 1ps

module ats_cordic import ats_pkg::*; #(
  parameter int CW = DEF_COORD_BITS + 17
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] p_in,
  input  logic signed [CW-1:0] q_in,
  input  logic signed [31:0]   w_in,
  output logic signed [CW-1:0] p_out,
  output logic signed [CW-1:0] q_out
);

  logic signed [CW-1:0] a_q [ITERS];
  logic signed [CW-1:0] b_q [ITERS];
  logic signed [31:0]   w_q [ITERS];

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    logic signed [CW-1:0] a_in;
    logic signed [CW-1:0] b_in;
    logic signed [31:0]   w_in_i;
    logic signed [CW-1:0] da;
    logic signed [CW-1:0] db;
    logic signed [31:0]   ang;

    if (i == 0) begin : g_first
      assign a_in   = p_in;
      assign b_in   = q_in;
      assign w_in_i = w_in;
    end else begin : g_next
      assign a_in   = a_q[i-1];
      assign b_in   = b_q[i-1];
      assign w_in_i = w_q[i-1];
    end

    assign da  = b_in >>> i;
    assign db  = a_in >>> i;
    assign ang = $signed(atan_turn(i));

    always_ff @(posedge clk) begin
      if (en) begin
        if (!w_in_i[31]) begin
          a_q[i] <= a_in - da;
          b_q[i] <= b_in + db;
          w_q[i] <= w_in_i - ang;
        end else begin
          a_q[i] <= a_in + da;
          b_q[i] <= b_in - db;
          w_q[i] <= w_in_i + ang;
        end
      end
    end
  end

  assign p_out = a_q[ITERS-1];
  assign q_out = b_q[ITERS-1];

endmodule
